// ===== hdl/alsw_pkg.sv =====
// ----------------------------------------------------------------------------
// alsw_pkg
// shared types and pipeline depths of the area light sample weight core
// ----------------------------------------------------------------------------
package alsw_pkg;

  localparam int GEOM_LAT  = 6;
  localparam int QUOT_LAT  = 32;
  // per channel: fraction divider stages and final divider stages
  localparam int FDIV      = 48;
  localparam int ZDIV      = 32;
  localparam int CHAN_LAT  = 2 + FDIV + 2 + ZDIV;
  localparam int DLY_LAT   = QUOT_LAT + CHAN_LAT;
  localparam int TOTAL_LAT = GEOM_LAT + DLY_LAT + 1;

  typedef enum logic [2:0] {
    REG_CORNER = 3'd0,
    REG_EDGE_U = 3'd1,
    REG_EDGE_V = 3'd2,
    REG_NORMAL = 3'd3,
    REG_AREA   = 3'd4,
    REG_COLOR  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [62:0] corner;
    logic [62:0] edge_u;
    logic [62:0] edge_v;
    logic [47:0] normal;
  } light_geom_t;

  // incidence vector and weight kill flag, carried beside the dividers
  typedef struct packed {
    logic [2:0][23:0] d;
    logic             zero;
  } side_t;

endpackage

// ===== hdl/alsw_geom.sv =====
// ----------------------------------------------------------------------------
// alsw_geom
// light point, incidence, cosine dot products, squared distance and A*B
// ----------------------------------------------------------------------------
module alsw_geom (
  input  logic                 clk,
  input  logic                 en,
  input  alsw_pkg::light_geom_t light,
  input  logic [62:0]          point,
  input  logic [47:0]          normal,
  input  logic [15:0]          u,
  input  logic [15:0]          v,
  output logic [79:0]          num,
  output logic [47:0]          den,
  output alsw_pkg::side_t      side
);
  import alsw_pkg::*;

  logic signed [20:0] cr [3];
  logic signed [20:0] eu [3];
  logic signed [20:0] ev [3];
  logic signed [20:0] pt [3];
  logic signed [15:0] ln [3];
  logic signed [15:0] nv [3];

  logic signed [37:0] pu1 [3];
  logic signed [37:0] pv1 [3];
  logic signed [21:0] base1 [3];
  logic signed [15:0] n1 [3];

  logic signed [39:0] diff [3];
  logic signed [39:0] rnd [3];
  logic signed [23:0] dsat [3];
  logic signed [23:0] d2 [3];
  logic signed [15:0] n2 [3];

  logic signed [39:0] nd3 [3];
  logic signed [39:0] ld3 [3];
  logic signed [47:0] sq3 [3];
  logic [2:0][23:0]   d3;

  logic signed [41:0] ndsum;
  logic signed [41:0] ldsum;
  logic signed [41:0] ldneg;
  logic [47:0]        ssum;
  logic [39:0]        a_val;
  logic [39:0]        b_val;

  logic [39:0]        a4;
  logic [39:0]        b4;
  logic [47:0]        s4;
  side_t              side4;

  logic [59:0]        pa5;
  logic [59:0]        pb5;
  logic [47:0]        s5;
  side_t              side5;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      cr[c] = $signed(light.corner[21*c +: 21]);
      eu[c] = $signed(light.edge_u[21*c +: 21]);
      ev[c] = $signed(light.edge_v[21*c +: 21]);
      ln[c] = $signed(light.normal[16*c +: 16]);
      pt[c] = $signed(point[21*c +: 21]);
      nv[c] = $signed(normal[16*c +: 16]);
    end
  end

  // round half up to 11 fraction bits, then clamp to 24 bits
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      diff[c] = (40'(base1[c]) <<< 16) + 40'(pu1[c]) + 40'(pv1[c]) + 40'sd32768;
      rnd[c]  = diff[c] >>> 16;
      if (rnd[c] > 40'sd8388607) begin
        dsat[c] = 24'sh7FFFFF;
      end else if (rnd[c] < -40'sd8388608) begin
        dsat[c] = -24'sh800000;
      end else begin
        dsat[c] = rnd[c][23:0];
      end
    end
  end

  always_comb begin
    ndsum = 42'(nd3[0]) + 42'(nd3[1]) + 42'(nd3[2]);
    ldsum = 42'(ld3[0]) + 42'(ld3[1]) + 42'(ld3[2]);
    ldneg = -ldsum;
    ssum  = 48'(sq3[0]) + 48'(sq3[1]) + 48'(sq3[2]);
    a_val = (ndsum > 42'sd0) ? ndsum[39:0] : 40'd0;
    b_val = (ldsum < 42'sd0) ? ldneg[39:0] : 40'd0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        pu1[c]   <= 38'($signed({1'b0, u})) * 38'(eu[c]);
        pv1[c]   <= 38'($signed({1'b0, v})) * 38'(ev[c]);
        base1[c] <= 22'(cr[c]) - 22'(pt[c]);
        n1[c]    <= nv[c];
        d2[c]    <= dsat[c];
        n2[c]    <= n1[c];
        nd3[c]   <= 40'(n2[c]) * 40'(d2[c]);
        ld3[c]   <= 40'(ln[c]) * 40'(d2[c]);
        sq3[c]   <= 48'(d2[c]) * 48'(d2[c]);
        d3[c]    <= d2[c];
      end
      a4         <= a_val;
      b4         <= b_val;
      s4         <= ssum;
      side4.d    <= d3;
      side4.zero <= (ssum == 48'd0) || (a_val == 40'd0) || (b_val == 40'd0);
      pa5        <= 60'(a4) * 60'(b4[19:0]);
      pb5        <= 60'(a4) * 60'(b4[39:20]);
      s5         <= s4;
      side5      <= side4;
      num        <= 80'(pa5) + {pb5, 20'd0};
      den        <= s5;
      side       <= side5;
    end
  end

endmodule

// ===== hdl/alsw_quot.sv =====
// ----------------------------------------------------------------------------
// alsw_quot
// restoring divider, one quotient bit per stage: q = A*B / S with remainder
// ----------------------------------------------------------------------------
module alsw_quot (
  input  logic        clk,
  input  logic        en,
  input  logic [79:0] num,
  input  logic [47:0] den,
  output logic [31:0] quo,
  output logic [47:0] rem,
  output logic [47:0] den_o
);
  import alsw_pkg::*;

  logic [47:0] rem_r [QUOT_LAT];
  logic [31:0] quo_r [QUOT_LAT];
  logic [31:0] lo_r  [QUOT_LAT];
  logic [47:0] den_r [QUOT_LAT];

  genvar k;
  generate
    for (k = 0; k < QUOT_LAT; k++) begin : g_stage
      logic [47:0] rem_in;
      logic [31:0] quo_in;
      logic [31:0] lo_in;
      logic [47:0] den_in;
      logic [48:0] t;
      logic [48:0] dif;
      logic        ge;
      if (k == 0) begin : g_first
        // quotient fits 32 bits, so the top word is already below S
        assign rem_in = num[79:32];
        assign quo_in = 32'd0;
        assign lo_in  = num[31:0];
        assign den_in = den;
      end else begin : g_next
        assign rem_in = rem_r[k-1];
        assign quo_in = quo_r[k-1];
        assign lo_in  = lo_r[k-1];
        assign den_in = den_r[k-1];
      end
      always_comb begin
        t   = {rem_in, lo_in[31]};
        dif = t - {1'b0, den_in};
        ge  = !dif[48];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? dif[47:0] : t[47:0];
          quo_r[k] <= {quo_in[30:0], ge};
          lo_r[k]  <= {lo_in[30:0], 1'b0};
          den_r[k] <= den_in;
        end
      end
    end
  endgenerate

  assign quo   = quo_r[QUOT_LAT-1];
  assign rem   = rem_r[QUOT_LAT-1];
  assign den_o = den_r[QUOT_LAT-1];

endmodule

// ===== hdl/alsw_chan.sv =====
// ----------------------------------------------------------------------------
// alsw_chan
// one color channel: floor(A*B*M/S) then divide by S*2^14 with saturation
// ----------------------------------------------------------------------------
module alsw_chan (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] quo,
  input  logic [47:0] rem,
  input  logic [47:0] den,
  input  logic [47:0] m,
  output logic [31:0] val,
  output logic        sat
);
  import alsw_pkg::*;

  logic [71:0] pr0;
  logic [71:0] pr1;
  logic [55:0] pq0;
  logic [55:0] pq1;
  logic [47:0] den1;
  logic [95:0] x2;
  logic [79:0] y2;
  logic [47:0] den2;

  logic [47:0] frem [FDIV];
  logic [47:0] fquo [FDIV];
  logic [47:0] flo  [FDIV];
  logic [79:0] fy   [FDIV];
  logic [47:0] fden [FDIV];

  logic [79:0] y51;
  logic [47:0] den51;

  logic [61:0] rem52;
  logic [31:0] lo52;
  logic [61:0] dd52;
  logic        sat52;

  logic [61:0] zrem [ZDIV];
  logic [31:0] zquo [ZDIV];
  logic [31:0] zlo  [ZDIV];
  logic [61:0] zdd  [ZDIV];
  logic        zsat [ZDIV];

  always_ff @(posedge clk) begin
    if (en) begin
      pr0   <= 72'(rem) * 72'(m[23:0]);
      pr1   <= 72'(rem) * 72'(m[47:24]);
      pq0   <= 56'(quo) * 56'(m[23:0]);
      pq1   <= 56'(quo) * 56'(m[47:24]);
      den1  <= den;
      x2    <= 96'(pr0) + {pr1, 24'd0};
      y2    <= 80'(pq0) + {pq1, 24'd0};
      den2  <= den1;
      y51   <= fy[FDIV-1] + 80'(fquo[FDIV-1]);
      den51 <= fden[FDIV-1];
      rem52 <= {14'd0, y51[79:32]};
      lo52  <= y51[31:0];
      dd52  <= {den51, 14'd0};
      sat52 <= {14'd0, y51[79:32]} >= {den51, 14'd0};
    end
  end

  genvar k;
  generate
    // fractional part: floor(r*M / S), r below S
    for (k = 0; k < FDIV; k++) begin : g_fdiv
      logic [47:0] rem_in;
      logic [47:0] quo_in;
      logic [47:0] lo_in;
      logic [79:0] y_in;
      logic [47:0] den_in;
      logic [48:0] t;
      logic [48:0] dif;
      logic        ge;
      if (k == 0) begin : g_first
        assign rem_in = x2[95:48];
        assign quo_in = 48'd0;
        assign lo_in  = x2[47:0];
        assign y_in   = y2;
        assign den_in = den2;
      end else begin : g_next
        assign rem_in = frem[k-1];
        assign quo_in = fquo[k-1];
        assign lo_in  = flo[k-1];
        assign y_in   = fy[k-1];
        assign den_in = fden[k-1];
      end
      always_comb begin
        t   = {rem_in, lo_in[47]};
        dif = t - {1'b0, den_in};
        ge  = !dif[48];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          frem[k] <= ge ? dif[47:0] : t[47:0];
          fquo[k] <= {quo_in[46:0], ge};
          flo[k]  <= {lo_in[46:0], 1'b0};
          fy[k]   <= y_in;
          fden[k] <= den_in;
        end
      end
    end

    // final quotient by S*2^14, only meaningful when not saturated
    for (k = 0; k < ZDIV; k++) begin : g_zdiv
      logic [61:0] rem_in;
      logic [31:0] quo_in;
      logic [31:0] lo_in;
      logic [61:0] dd_in;
      logic        sat_in;
      logic [62:0] t;
      logic [62:0] dif;
      logic        ge;
      if (k == 0) begin : g_first
        assign rem_in = rem52;
        assign quo_in = 32'd0;
        assign lo_in  = lo52;
        assign dd_in  = dd52;
        assign sat_in = sat52;
      end else begin : g_next
        assign rem_in = zrem[k-1];
        assign quo_in = zquo[k-1];
        assign lo_in  = zlo[k-1];
        assign dd_in  = zdd[k-1];
        assign sat_in = zsat[k-1];
      end
      always_comb begin
        t   = {rem_in, lo_in[31]};
        dif = t - {1'b0, dd_in};
        ge  = !dif[62];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          zrem[k] <= ge ? dif[61:0] : t[61:0];
          zquo[k] <= {quo_in[30:0], ge};
          zlo[k]  <= {lo_in[30:0], 1'b0};
          zdd[k]  <= dd_in;
          zsat[k] <= sat_in;
        end
      end
    end
  endgenerate

  assign val = zquo[ZDIV-1];
  assign sat = zsat[ZDIV-1];

endmodule

// ===== hdl/area_light_sample_weight_core.sv =====
// from input request to output request the path is mostly the
// bit-per-stage divider chains
// throughput: one request per cycle unless the output stalls; every stage is registered
// a stalled output holds every stage; nothing is dropped or repeated
// reset clears the light registers and all stage valid bits
// ----------------------------------------------------------------------------
// area_light_sample_weight_core
// samples a parallelogram light and weights its color by the geometry term
// ----------------------------------------------------------------------------
module area_light_sample_weight_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // point_x, point_y, point_z, normal_x, normal_y, normal_z, sample_u, sample_v
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // incidence_x, incidence_y, incidence_z, intensity_red, intensity_green,
  // intensity_blue
  output logic [167:0] m_tdata,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [62:0]  cfg_wdata
);
  import alsw_pkg::*;

  light_geom_t light;
  logic [31:0] light_area;
  logic [47:0] light_color;
  logic [47:0] m [3];

  logic                  en;
  logic [TOTAL_LAT-1:0]  vld;

  logic [79:0] g_num;
  logic [47:0] g_den;
  side_t       g_side;
  logic [31:0] q_quo;
  logic [47:0] q_rem;
  logic [47:0] q_den;
  logic [31:0] c_val [3];
  logic        c_sat [3];
  side_t       dly [DLY_LAT];

  logic [2:0][31:0] inten;

  always_ff @(posedge clk) begin
    if (rst) begin
      light       <= '0;
      light_area  <= '0;
      light_color <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_CORNER: light.corner <= cfg_wdata;
        REG_EDGE_U: light.edge_u <= cfg_wdata;
        REG_EDGE_V: light.edge_v <= cfg_wdata;
        REG_NORMAL: light.normal <= cfg_wdata[47:0];
        REG_AREA:   light_area   <= cfg_wdata[31:0];
        REG_COLOR:  light_color  <= cfg_wdata[47:0];
        default: begin
        end
      endcase
    end
  end

  // area times color per channel, settles while the block is idle
  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      m[c] <= 48'(light_area) * 48'(light_color[16*c +: 16]);
    end
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[TOTAL_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[TOTAL_LAT-2:0], s_tvalid};
    end
  end

  alsw_geom u_geom (
    .clk    (clk),
    .en     (en),
    .light  (light),
    .point  (s_tdata[62:0]),
    .normal (s_tdata[110:63]),
    .u      (s_tdata[126:111]),
    .v      (s_tdata[142:127]),
    .num    (g_num),
    .den    (g_den),
    .side   (g_side)
  );

  alsw_quot u_quot (
    .clk   (clk),
    .en    (en),
    .num   (g_num),
    .den   (g_den),
    .quo   (q_quo),
    .rem   (q_rem),
    .den_o (q_den)
  );

  genvar c;
  generate
    for (c = 0; c < 3; c++) begin : g_chan
      alsw_chan u_chan (
        .clk (clk),
        .en  (en),
        .quo (q_quo),
        .rem (q_rem),
        .den (q_den),
        .m   (m[c]),
        .val (c_val[c]),
        .sat (c_sat[c])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      dly[0] <= g_side;
      for (int k = 1; k < DLY_LAT; k++) begin
        dly[k] <= dly[k-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (dly[DLY_LAT-1].zero) begin
        inten[k] = 32'd0;
      end else if (c_sat[k]) begin
        inten[k] = 32'hFFFFFFFF;
      end else begin
        inten[k] = c_val[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {inten, dly[DLY_LAT-1].d};
    end
  end

endmodule

// ===== sim/area_light_sample_weight_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// area_light_sample_weight_checker
// watches the request and result channels, predicts each sample's incidence
// vector and weighted color, and compares them in order
// ----------------------------------------------------------------------------
module area_light_sample_weight_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [167:0] m_tdata,
  input  logic         cfg_wen,
  input  logic [2:0]   cfg_index,
  input  logic [62:0]  cfg_wdata,
  output int           errors,
  output int           pending,
  output int           samples_seen,
  output int           lit_seen
);
  import alsw_pkg::*;

  logic [62:0]  corner_r, edge_u_r, edge_v_r;
  logic [47:0]  normal_r, color_r;
  logic [31:0]  area_r;
  logic [167:0] expected_q[$];

  function automatic logic [167:0] weigh_sample(input logic [143:0] req);
    logic signed [23:0]  d[3];
    logic signed [63:0]  diff, nd, ld, rounded;
    logic [63:0]         s, a, b;
    logic [255:0]        num, den, q;
    logic [31:0]         chan[3];
    logic [167:0]        res;
    logic [15:0]         u, v;
    u = req[126:111];
    v = req[142:127];
    nd = 0;
    ld = 0;
    s = 0;
    for (int c = 0; c < 3; c++) begin
      diff = 64'($signed(corner_r[21*c +: 21])) * 65536
           + $signed({1'b0, u}) * 64'($signed(edge_u_r[21*c +: 21]))
           + $signed({1'b0, v}) * 64'($signed(edge_v_r[21*c +: 21]))
           - 64'($signed(req[21*c +: 21])) * 65536;
      rounded = (diff + 32768) >>> 16;
      if (rounded > 8388607) rounded = 8388607;
      else if (rounded < -8388608) rounded = -8388608;
      d[c] = rounded[23:0];
      nd += 64'($signed(req[63 + 16*c +: 16])) * d[c];
      ld += 64'($signed(normal_r[16*c +: 16])) * d[c];
      s += 64'(d[c]) * 64'(d[c]);
    end
    a = nd > 0 ? nd : 0;
    b = ld < 0 ? -ld : 0;
    for (int c = 0; c < 3; c++) begin
      if (s == 0 || a == 0 || b == 0) begin
        chan[c] = 0;
      end else begin
        num = 256'(a) * 256'(b) * 256'(area_r) * 256'(color_r[16*c +: 16]);
        den = 256'(s) * 256'(s) << 14;
        q = num / den;
        chan[c] = (q > 256'hFFFFFFFF) ? 32'hFFFFFFFF : q[31:0];
      end
    end
    res = {chan[2], chan[1], chan[0], d[2], d[1], d[0]};
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_r <= '0; edge_u_r <= '0; edge_v_r <= '0;
      normal_r <= '0; area_r <= '0; color_r <= '0;
      expected_q.delete();
      errors <= 0; samples_seen <= 0; lit_seen <= 0;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_CORNER: corner_r <= cfg_wdata;
          REG_EDGE_U: edge_u_r <= cfg_wdata;
          REG_EDGE_V: edge_v_r <= cfg_wdata;
          REG_NORMAL: normal_r <= cfg_wdata[47:0];
          REG_AREA:   area_r   <= cfg_wdata[31:0];
          REG_COLOR:  color_r  <= cfg_wdata[47:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        expected_q.insert(expected_q.size(), weigh_sample(s_tdata));
      end
      if (m_tvalid && m_tready) begin
        samples_seen <= samples_seen + 1;
        if (m_tdata[167:72] != '0) lit_seen <= lit_seen + 1;
        if (expected_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", m_tdata);
          errors <= errors + 1;
        end else begin
          if (expected_q[0] != m_tdata) begin
            if (errors < 10) begin
              $display("mismatch: expected %h", expected_q[0]);
              $display("          actual   %h", m_tdata);
            end
            errors <= errors + 1;
          end
          void'(expected_q.pop_front());
        end
      end
    end
  end

  assign pending = expected_q.size();

endmodule

// ===== sim/area_light_sample_weight_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// area_light_sample_weight_core_test
// drives random and corner-case shading samples under several light setups
// with random stalls on both sides; the checker predicts and compares
// ----------------------------------------------------------------------------
module area_light_sample_weight_core_test;
  import alsw_pkg::*;

  logic         clk, rst;
  logic         s_tvalid, s_tready, m_tvalid, m_tready;
  logic [143:0] s_tdata;
  logic [167:0] m_tdata;
  logic         cfg_wen;
  logic [2:0]   cfg_index;
  logic [62:0]  cfg_wdata;
  int           errors, pending, samples_seen, lit_seen;
  bit           drain_done;

  area_light_sample_weight_core dut (.*);
  area_light_sample_weight_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [20:0] coord(input int mode);
    case (mode)
      0: return 21'h100000;
      1: return 21'h0FFFFF;
      2: return 21'($signed($urandom_range(0, 16383)) - 8192);
      default: return 21'($urandom);
    endcase
  endfunction

  function automatic logic [62:0] vec3(input int mode);
    return {coord(mode), coord(mode), coord(mode)};
  endfunction

  // receiver stalls
  initial begin
    m_tready = 0;
    @(negedge clk);
    while (!drain_done) begin
      if ($urandom_range(0, 3) == 0) begin
        m_tready <= 0;
        repeat (gap_len() + 1) @(negedge clk);
      end
      m_tready <= 1;
      repeat ($urandom_range(1, 20)) @(negedge clk);
    end
    m_tready <= 1;
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [62:0] val);
    cfg_wen <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wen <= 0;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    while (pending != 0) @(negedge clk);
    repeat (TOTAL_LAT + 10) @(negedge clk);
  endtask

  task automatic send_sample(input logic [143:0] req);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 0;
      repeat (g) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= req;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [143:0] rand_sample(input int mode);
    logic [143:0] r;
    r[62:0] = vec3(mode);
    for (int c = 0; c < 3; c++) r[63 + 16*c +: 16] = 16'($urandom);
    if (mode == 2 && $urandom_range(0, 1)) r[63 +: 48] = {16'h0000, 16'h0000, 16'h4000};
    r[126:111] = 16'($urandom);
    r[142:127] = 16'($urandom);
    r[143]     = 1'b0;
    return r;
  endfunction

  task automatic light_setup(input int setup);
    case (setup)
      0: begin // light above origin facing down, modest colors
        write_reg(REG_CORNER, {21'h000800, 21'h1FF800, 21'h1FF800});
        write_reg(REG_EDGE_U, {21'h0, 21'h0, 21'h001000});
        write_reg(REG_EDGE_V, {21'h0, 21'h001000, 21'h0});
        write_reg(REG_NORMAL, 63'({16'hC000, 16'h0000, 16'h0000}));
        write_reg(REG_AREA, 63'h0001_0000);
        write_reg(REG_COLOR, 63'({16'h0100, 16'h0200, 16'h0080}));
      end
      1: begin // extremes
        write_reg(REG_CORNER, vec3(0));
        write_reg(REG_EDGE_U, vec3(1));
        write_reg(REG_EDGE_V, vec3(1));
        write_reg(REG_NORMAL, 63'({16'h8000, 16'h8000, 16'h8000}));
        write_reg(REG_AREA, 63'hFFFF_FFFF);
        write_reg(REG_COLOR, 63'({16'hFFFF, 16'hFFFF, 16'hFFFF}));
      end
      default: begin
        write_reg(REG_CORNER, vec3(2));
        write_reg(REG_EDGE_U, vec3(2));
        write_reg(REG_EDGE_V, vec3(2));
        write_reg(REG_NORMAL, 63'({$urandom, $urandom}));
        write_reg(REG_AREA, 63'($urandom));
        write_reg(REG_COLOR, 63'({$urandom, $urandom}));
      end
    endcase
  endtask

  initial begin
    logic [143:0] req;
    drain_done = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    cfg_wen = 0;
    cfg_index = REG_CORNER;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // reset registers: everything weighs to zero
    send_sample('0);
    send_sample(144'({32'hFFFF_FFFF, {48{1'b1}}, vec3(1)}));
    s_tvalid <= 0;
    wait_idle();

    light_setup(0);
    // directed: zero distance, back facing, extremes of fields
    req = '0;
    req[62:0] = {21'h000800, 21'h1FF800, 21'h1FF800};
    send_sample(req);
    req = '0;
    req[63 +: 48] = {16'h0000, 16'h0000, 16'h4000};
    req[142:111] = {16'h8000, 16'h8000};
    send_sample(req);
    req[63 +: 48] = {16'h0000, 16'h0000, 16'hC000};
    send_sample(req);
    req[63 +: 48] = {16'h4000, 16'h0000, 16'h0000};
    send_sample(req);
    req[63 +: 48] = {16'h7FFF, 16'h7FFF, 16'h7FFF};
    req[142:111] = {16'hFFFF, 16'hFFFF};
    send_sample(req);
    req[62:0] = {21'h100000, 21'h100000, 21'h100000};
    send_sample(req);
    req[62:0] = {21'h0FFFFF, 21'h0FFFFF, 21'h0FFFFF};
    req[63 +: 48] = {16'h8000, 16'h8000, 16'h8000};
    send_sample(req);
    for (int i = 0; i < 10; i++) send_sample(rand_sample(i % 4));
    s_tvalid <= 0;
    wait_idle();

    for (int phase = 0; phase < 5; phase++) begin
      light_setup(phase == 1 ? 1 : (phase == 3 ? 0 : 2));
      for (int i = 0; i < 106; i++) begin
        send_sample(rand_sample(phase == 1 ? $urandom_range(0, 3) :
                                ($urandom_range(0, 4) == 0 ? 3 : 2)));
      end
      s_tvalid <= 0;
      // hold off until the pipeline has drained
      wait_idle();
    end
    write_reg(REG_NORMAL, 63'({16'h0, 16'h0, 16'h0}));
    s_tvalid <= 0;

    drain_done = 1;
    wait_idle();
    $display("covered %0d samples over several light setups, %0d with nonzero weight",
             samples_seen, lit_seen);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
